/* sv/lwcr_pkg.sv */
// Shared types and constants for the location weighted choice core.
// Used by the core module; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package lwcr_pkg;

    localparam int LWCR_MAX_LOCATIONS = 16;
    localparam int LWCR_MAX_CHOICES   = 8;
    localparam int LWCR_FRAC_BITS     = 16;

    // Width of time stamps and of the divisor path of the shared divider.
    localparam int TIME_W = 20;
    localparam int DEN_W  = 20;
    // Twelve months of one year in Q16: the inflation denominator.
    localparam logic [DEN_W-1:0] MONTH_DEN = 20'd786432;
    // The same denominator is three times two to the power YEAR_SH.
    localparam int YEAR_SH = 18;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_LOAD   = 2'd1,
        OP_START  = 2'd2,
        OP_TICK   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        SEL_CURRENT = 2'd0,
        SEL_START   = 2'd1,
        SEL_PEAK    = 2'd2,
        SEL_NONE    = 2'd3
    } t_sel;

    typedef enum logic [2:0] {
        CFG_NUM_CHOICES   = 3'd0,
        CFG_NUM_LOCATIONS = 3'd1,
        CFG_RAMP_MODE     = 3'd2,
        CFG_PEAK_AFTER    = 3'd3,
        CFG_INFLATION     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]  operation;
        logic [1:0]  table_select;
        logic [3:0]  location;
        logic [2:0]  choice_index;
        logic [16:0] weight_value;
        logic [15:0] random_value;
        logic [19:0] time_value;
    } t_in_word;

    typedef struct packed {
        logic [2:0] chosen_index;
        logic       weights_changed;
    } t_out_word;

endpackage
`default_nettype wire

/* sv/lwcr_ram.sv */
// Generic single write port RAM with one registered read port.
// Stand-alone; used for the three weight tables of the core.
`timescale 1ns / 1ps
`default_nettype none
module lwcr_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* sv/lwcr_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on no other file; no sub-modules.
`timescale 1ns / 1ps
`default_nettype none
module lwcr_div #(
    parameter int NUM_W = 37,
    parameter int DIV_W = 20
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DIV_W-1:0] i_den,
    output      logic             o_busy,
    output      logic             o_done,
    output      logic [NUM_W-1:0] o_quo
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DIV_W:0]   rem_sh;
    logic [DIV_W:0]   trial;
    logic             fits;

    assign rem_sh = {r_rem, r_q[NUM_W-1]};
    assign trial  = rem_sh - {1'b0, r_den};
    assign fits   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_W-2:0], fits};
            r_rem <= fits ? trial[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule
`default_nettype wire

/* sv/location_weighted_choice_with_ramp_core.sv */
// A sample walks the running sum weight by weight, at most num_choices weights; a load or a
// start time needs no walk. A tick uses the shared divider: inflation divides once per row
// and the ramp once per weight.
// One word is in work at a time; the next is taken once the result sits in the output register.
// Reset (synchronous, active low) restores the control and configuration registers and clears the start time;
// the weight tables are not cleared and hold nothing meaningful until loaded.
`timescale 1ns / 1ps
`default_nettype none
module location_weighted_choice_with_ramp_core #(
    parameter int MAX_LOCATIONS = lwcr_pkg::LWCR_MAX_LOCATIONS,
    parameter int MAX_CHOICES   = lwcr_pkg::LWCR_MAX_CHOICES,
    parameter int FRAC_BITS     = lwcr_pkg::LWCR_FRAC_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output      logic                o_in_ready,
    input  wire lwcr_pkg::t_in_word  i_in_word,
    output      logic                o_out_valid,
    input  wire logic                i_out_ready,
    output      lwcr_pkg::t_out_word o_out_word,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_index,
    input  wire logic [15:0]         i_cfg_data
);
    import lwcr_pkg::*;

    // Weight width, table geometry and the widths of the shared datapath.
    localparam int W     = FRAC_BITS + 1;
    localparam int DEPTH = MAX_LOCATIONS * MAX_CHOICES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CIW   = $clog2(MAX_CHOICES);
    localparam int LW    = (MAX_LOCATIONS > 1) ? $clog2(MAX_LOCATIONS) : 1;
    localparam int NCW   = $clog2(MAX_CHOICES + 1);
    localparam int NLW   = $clog2(MAX_LOCATIONS + 1);
    localparam int SW    = W + CIW;
    localparam int DVD   = W + TIME_W;
    localparam int MAW   = DVD - YEAR_SH;
    localparam int MBW   = (FRAC_BITS > TIME_W) ? FRAC_BITS : TIME_W;
    localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;
    // One third scaled by two to the power FRAC_BITS and rounded up. Multiplying by it and
    // dropping FRAC_BITS bits gives the exact floor of a third for the dividends met here.
    localparam logic [MBW-1:0] RECIP3 = MBW'(((64'd1 << FRAC_BITS) + 64'd2) / 64'd3);

    typedef enum logic [19:0] {
        S_IDLE = 20'h00001,
        S_DEC  = 20'h00002,
        S_SRD  = 20'h00004,
        S_SACC = 20'h00008,
        S_RCHW = 20'h00010,
        S_RCHK = 20'h00020,
        S_RRD  = 20'h00040,
        S_RLAT = 20'h00080,
        S_RMUL = 20'h00100,
        S_RDS  = 20'h00200,
        S_RDW  = 20'h00400,
        S_IRD  = 20'h00800,
        S_ILAT = 20'h01000,
        S_IMUL = 20'h02000,
        S_IDS  = 20'h04000,
        S_IDW  = 20'h08000,
        S_IDS2 = 20'h10000,
        S_IDW2 = 20'h20000,
        S_IWR  = 20'h40000,
        S_DONE = 20'h80000
    } t_state;

    // Control state.
    t_state            r_state, n_state;
    logic              r_out_valid, n_out_valid;
    logic [3:0]        r_nc;
    logic [4:0]        r_nl;
    logic              r_mode;
    logic [15:0]       r_pad;
    logic [15:0]       r_infl;
    logic [TIME_W-1:0] r_ramp_start, n_ramp_start;

    // Working registers of the sequencer and the shared datapath.
    t_in_word          r_item;
    t_out_word         r_out_word, n_out_word;
    logic [AW-1:0]     r_addr, n_addr;
    logic [AW-1:0]     r_base, n_base;
    logic [CIW-1:0]    r_i, n_i;
    logic [LW-1:0]     r_loc, n_loc;
    logic [SW-1:0]     r_sum, n_sum;
    logic [2:0]        r_res_idx, n_res_idx;
    logic              r_res_chg, n_res_chg;
    logic [W-1:0]      r_opa, n_opa;
    logic [TIME_W-1:0] r_opb, n_opb;
    logic [DVD-1:0]    r_prod, n_prod;
    logic              r_eneg, n_eneg;
    logic              r_neg, n_neg;
    logic [W-1:0]      r_start, n_start;
    logic [W-1:0]      r_w0, n_w0;
    logic [W-1:0]      r_other, n_other;

    // Table ports.
    logic [W-1:0]      cur_rd, start_rd, peak_rd;
    logic              we_cur, we_start, we_peak;
    logic [AW-1:0]     waddr;
    logic [W-1:0]      wdata;

    // Shared divider.
    logic              div_start, div_busy, div_done;
    logic [DVD-1:0]    div_num, div_quo;
    logic [DEN_W-1:0]  div_den;

    // Shared multiplier.
    logic [MAW-1:0]    mul_a;
    logic [MBW-1:0]    mul_b;
    logic [DVD-1:0]    mul_p;

    // Derived values.
    logic [NCW-1:0]    nc_use;
    logic [CIW-1:0]    n_last;
    logic [NLW-1:0]    nl_use;
    logic [LW-1:0]     loc_last;
    logic [FRAC_BITS+15:0] tgt_wide;
    logic [SW-1:0]     target;
    logic [SW-1:0]     sum_next;
    logic [AW-1:0]     item_addr;
    logic [W-1:0]      load_w;
    logic [15:0]       span;
    logic [W-1:0]      ramp_w;
    logic [DVD:0]      ramp_sum;
    logic [W:0]        infl_sum;
    logic [W-1:0]      infl_w0;
    logic              in_fire;
    logic              out_fire;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = o_out_valid && i_out_ready;

    // The choice count is held to 2..MAX_CHOICES, the location count to MAX_LOCATIONS.
    always_comb begin
        if (r_nc < 4'd2) begin
            nc_use = NCW'(2);
        end else if (32'(r_nc) > MAX_CHOICES) begin
            nc_use = NCW'(MAX_CHOICES);
        end else begin
            nc_use = NCW'(r_nc);
        end
        if (32'(r_nl) > MAX_LOCATIONS) begin
            nl_use = NLW'(MAX_LOCATIONS);
        end else begin
            nl_use = NLW'(r_nl);
        end
    end
    assign n_last   = CIW'(nc_use - 1'b1);
    assign loc_last = LW'(nl_use - 1'b1);

    // The random fraction is rescaled from sixteen bits to the weight precision.
    assign tgt_wide  = {r_item.random_value, {FRAC_BITS{1'b0}}} >> 16;
    assign target    = SW'(tgt_wide[FRAC_BITS-1:0]);
    assign sum_next  = r_sum + SW'(cur_rd);
    assign item_addr = AW'(32'(r_item.location) * MAX_CHOICES + 32'(r_item.choice_index));
    assign load_w    = (32'(r_item.weight_value) > 32'(ONE)) ? ONE : W'(r_item.weight_value);
    // A zero ramp length behaves as one time unit.
    assign span      = (r_pad == 16'd0) ? 16'd1 : r_pad;

    // The one multiplier serves the ramp products, the inflation product and the
    // division of that product by three.
    always_comb begin
        if (r_state == S_IDS) begin
            mul_a = MAW'(r_prod[DVD-1:YEAR_SH]);
            mul_b = RECIP3;
        end else begin
            mul_a = MAW'(r_opa);
            mul_b = MBW'(r_opb);
        end
    end
    assign mul_p = DVD'(mul_a) * DVD'(mul_b);

    // Ramp weight: start plus the signed step, clamped to zero and one.
    assign ramp_sum = (DVD + 1)'(r_start) + {1'b0, div_quo};
    always_comb begin
        if (r_neg) begin
            ramp_w = (div_quo >= DVD'(r_start)) ? '0 : r_start - W'(div_quo);
        end else begin
            ramp_w = (ramp_sum > (DVD + 1)'(ONE)) ? ONE : W'(ramp_sum);
        end
    end
    // Inflated first weight: w0 * (den + f) / den is w0 plus the floor of w0 * f / den,
    // and den is three times a power of two. The result is saturated at one.
    assign infl_sum = (W + 1)'(r_opa) + (W + 1)'(r_prod[DVD-1:FRAC_BITS]);
    assign infl_w0  = (infl_sum > (W + 1)'(ONE)) ? ONE : W'(infl_sum);

    // Write port and divider operands, chosen by the sequencer state.
    always_comb begin
        we_cur    = 1'b0;
        we_start  = 1'b0;
        we_peak   = 1'b0;
        waddr     = r_addr;
        wdata     = load_w;
        div_start = 1'b0;
        div_num   = r_prod;
        div_den   = DEN_W'(span);
        case (r_state)
            S_DEC: begin
                waddr = item_addr;
                if (r_item.operation == OP_LOAD
                    && 32'(r_item.location) < MAX_LOCATIONS
                    && 32'(r_item.choice_index) < MAX_CHOICES) begin
                    we_cur   = (r_item.table_select == SEL_CURRENT);
                    we_start = (r_item.table_select == SEL_START);
                    we_peak  = (r_item.table_select == SEL_PEAK);
                end
            end
            S_RDS: begin
                div_start = 1'b1;
                div_den   = DEN_W'(span);
            end
            S_RDW: begin
                we_cur = div_done;
                wdata  = ramp_w;
            end
            S_IDS2: begin
                div_start = 1'b1;
                div_num   = DVD'(ONE - r_w0);
                div_den   = DEN_W'(n_last);
            end
            S_IWR: begin
                we_cur = 1'b1;
                wdata  = (r_i == '0) ? r_w0 : r_other;
            end
            default: begin
            end
        endcase
    end

    // Sequencer. Samples walk the running sum with a read and an accumulate state per
    // weight; ticks go row by row through the one multiplier and the one divider.
    always_comb begin
        n_state      = r_state;
        n_ramp_start = r_ramp_start;
        n_addr       = r_addr;
        n_base       = r_base;
        n_i          = r_i;
        n_loc        = r_loc;
        n_sum        = r_sum;
        n_res_idx    = r_res_idx;
        n_res_chg    = r_res_chg;
        n_opa        = r_opa;
        n_opb        = r_opb;
        n_prod       = r_prod;
        n_eneg       = r_eneg;
        n_neg        = r_neg;
        n_start      = r_start;
        n_w0         = r_w0;
        n_other      = r_other;
        n_out_word   = r_out_word;
        n_out_valid  = out_fire ? 1'b0 : r_out_valid;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_res_idx = '0;
                n_res_chg = 1'b0;
                n_i       = '0;
                n_loc     = '0;
                n_sum     = '0;
                n_base    = '0;
                n_addr    = '0;
                n_state   = S_DONE;
                case (r_item.operation)
                    OP_SAMPLE: begin
                        if (32'(r_item.location) >= MAX_LOCATIONS) begin
                            n_res_idx = 3'(n_last);
                        end else begin
                            n_addr  = AW'(32'(r_item.location) * MAX_CHOICES);
                            n_state = S_SRD;
                        end
                    end
                    OP_START: begin
                        n_ramp_start = r_item.time_value;
                    end
                    OP_TICK: begin
                        if (r_mode) begin
                            n_eneg = r_item.time_value < r_ramp_start;
                            n_opb  = n_eneg ? r_ramp_start - r_item.time_value
                                            : r_item.time_value - r_ramp_start;
                            // Past the end of the ramp window the tick leaves the table alone.
                            if ((TIME_W + 1)'(r_item.time_value)
                                <= (TIME_W + 1)'(r_ramp_start) + (TIME_W + 1)'(r_pad)) begin
                                n_state = S_RCHW;
                            end
                        end else begin
                            n_opb = TIME_W'(r_infl);
                            if (nl_use != '0) begin
                                n_state = S_IRD;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SRD: begin
                n_state = S_SACC;
            end
            S_SACC: begin
                n_sum = sum_next;
                if (target <= sum_next || r_i == n_last) begin
                    n_res_idx = 3'(r_i);
                    n_state   = S_DONE;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_addr  = r_addr + 1'b1;
                    n_state = S_SRD;
                end
            end
            S_RCHW: begin
                n_state = S_RCHK;
            end
            S_RCHK: begin
                // A first weight already at one stops the ramp.
                if (cur_rd >= ONE || nl_use == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RRD;
                end
            end
            S_RRD: begin
                n_state = S_RLAT;
            end
            S_RLAT: begin
                n_start = start_rd;
                n_opa   = (peak_rd >= start_rd) ? peak_rd - start_rd : start_rd - peak_rd;
                n_neg   = (peak_rd < start_rd) ^ r_eneg;
                n_state = S_RMUL;
            end
            S_RMUL: begin
                n_prod  = mul_p;
                n_state = S_RDS;
            end
            S_RDS: begin
                n_state = S_RDW;
            end
            S_RDW: begin
                if (div_done) begin
                    if (r_i == n_last) begin
                        if (r_loc == loc_last) begin
                            n_res_chg = 1'b1;
                            n_state   = S_DONE;
                        end else begin
                            n_loc   = r_loc + 1'b1;
                            n_i     = '0;
                            n_base  = r_base + AW'(MAX_CHOICES);
                            n_addr  = r_base + AW'(MAX_CHOICES);
                            n_state = S_RRD;
                        end
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_addr  = r_addr + 1'b1;
                        n_state = S_RRD;
                    end
                end
            end
            S_IRD: begin
                n_state = S_ILAT;
            end
            S_ILAT: begin
                n_opa   = cur_rd;
                n_state = S_IMUL;
            end
            S_IMUL: begin
                // First weight times the yearly factor.
                n_prod  = mul_p;
                n_state = S_IDS;
            end
            S_IDS: begin
                // That product over 2^YEAR_SH, then a third of it by the reciprocal.
                n_prod  = mul_p;
                n_state = S_IDW;
            end
            S_IDW: begin
                n_w0    = infl_w0;
                n_state = S_IDS2;
            end
            S_IDS2: begin
                n_state = S_IDW2;
            end
            S_IDW2: begin
                if (div_done) begin
                    n_other = W'(div_quo);
                    n_i     = '0;
                    n_state = S_IWR;
                end
            end
            S_IWR: begin
                if (r_i == n_last) begin
                    if (r_loc == loc_last) begin
                        n_res_chg = 1'b1;
                        n_state   = S_DONE;
                    end else begin
                        n_loc   = r_loc + 1'b1;
                        n_i     = '0;
                        n_base  = r_base + AW'(MAX_CHOICES);
                        n_addr  = r_base + AW'(MAX_CHOICES);
                        n_state = S_IRD;
                    end
                end else begin
                    n_i    = r_i + 1'b1;
                    n_addr = r_addr + 1'b1;
                end
            end
            S_DONE: begin
                // The result moves to the output register once that is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out_word.chosen_index    = r_res_idx;
                    n_out_word.weights_changed = r_res_chg;
                    n_out_valid                = 1'b1;
                    n_state                    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_ramp_start <= '0;
            r_nc         <= 4'd8;
            r_nl         <= 5'd16;
            r_mode       <= 1'b0;
            r_pad        <= 16'd365;
            r_infl       <= 16'd0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_ramp_start <= n_ramp_start;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_NUM_CHOICES:   r_nc   <= i_cfg_data[3:0];
                    CFG_NUM_LOCATIONS: r_nl   <= i_cfg_data[4:0];
                    CFG_RAMP_MODE:     r_mode <= i_cfg_data[0];
                    CFG_PEAK_AFTER:    r_pad  <= i_cfg_data;
                    CFG_INFLATION:     r_infl <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item <= i_in_word;
        end
        r_out_word <= n_out_word;
        r_addr     <= n_addr;
        r_base     <= n_base;
        r_i        <= n_i;
        r_loc      <= n_loc;
        r_sum      <= n_sum;
        r_res_idx  <= n_res_idx;
        r_res_chg  <= n_res_chg;
        r_opa      <= n_opa;
        r_opb      <= n_opb;
        r_prod     <= n_prod;
        r_eneg     <= n_eneg;
        r_neg      <= n_neg;
        r_start    <= n_start;
        r_w0       <= n_w0;
        r_other    <= n_other;
    end

    lwcr_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_cur_ram (
        .i_clk   (i_clk),
        .i_we    (we_cur),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_addr),
        .o_rdata (cur_rd)
    );

    lwcr_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_start_ram (
        .i_clk   (i_clk),
        .i_we    (we_start),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_addr),
        .o_rdata (start_rd)
    );

    lwcr_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_peak_ram (
        .i_clk   (i_clk),
        .i_we    (we_peak),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_addr),
        .o_rdata (peak_rd)
    );

    lwcr_div #(.NUM_W(DVD), .DIV_W(DEN_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // The divider only runs while the sequencer waits for it.
    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> (r_state == S_RDW || r_state == S_IDW2))
        else $error("divider running outside a wait state");

    // The current table is only written by a load, a ramp step or an inflation row.
    a_cur_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we_cur |-> (r_state == S_DEC || r_state == S_RDW || r_state == S_IWR))
        else $error("current table written from an unexpected state");

    // Neither the sample walk nor the inflation writes pass the last choice in use.
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SACC || r_state == S_IWR) |-> (r_i <= n_last))
        else $error("choice counter past the last choice");

    // A waiting result is never overwritten by the next one.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(r_out_word))
        else $error("pending result overwritten");

endmodule
`default_nettype wire
